### design/ecu_pkg.sv
// Shared types and constants of the EWMA covariance update unit.
// Used by the top level, the update pipeline and the port checker.
package ecu_pkg;

   // fixed field widths
   localparam int SAMPLE_BITS     = 16;
   localparam int COV_BITS        = 48;
   localparam int ENTRY_IDX_BITS  = 3;
   localparam int DECAY_BITS      = 16;
   localparam int DIM_BITS        = 4;
   localparam int CSR_DATA_BITS   = 16;
   localparam int CSR_INDEX_BITS  = 1;
   localparam int LAMBDA_FRAC     = 15;

   localparam int MAX_DIM_DEFAULT = 8;

   localparam logic [DECAY_BITS-1:0] DECAY_ONE   = 16'h8000;
   localparam logic [DECAY_BITS-1:0] DECAY_RESET = 16'd30802;
   localparam logic [DIM_BITS-1:0]   DIM_RESET   = 4'd8;

   localparam logic signed [COV_BITS-1:0] COV_MAX_VAL = {1'b0, {(COV_BITS-1){1'b1}}};
   localparam logic signed [COV_BITS-1:0] COV_MIN_VAL = {1'b1, {(COV_BITS-1){1'b0}}};

   // command codes
   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DECAY     = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DIMENSION = 1'b1;

   typedef struct packed {
      logic                             cmd;
      logic [ENTRY_IDX_BITS-1:0]        entry_row;
      logic [ENTRY_IDX_BITS-1:0]        entry_col;
      logic signed [COV_BITS-1:0]       init_value;
      logic signed [SAMPLE_BITS-1:0]    sample;
   } ecu_req_type;

   typedef struct packed {
      logic [ENTRY_IDX_BITS-1:0]        out_row;
      logic [ENTRY_IDX_BITS-1:0]        out_col;
      logic signed [COV_BITS-1:0]       cov_value;
      logic                             saturated;
      logic                             last;
   } ecu_rsp_type;

   typedef struct packed {
      logic [ENTRY_IDX_BITS-1:0]        row;
      logic [ENTRY_IDX_BITS-1:0]        col;
      logic                             last;
   } ecu_tag_type;

   typedef struct packed {
      logic                             s1_vld;
      logic                             s2_vld;
   } ecu_pipe_status_type;

endpackage

### design/ewma_covariance_update_unit.sv
// Top level of the EWMA covariance update unit: registers, entry sequencer,
// covariance memory and result queue. Depends on ecu_pkg and ecu_update_pipe.
//
//   channel  ports                                     direction  moves
//   req      req_valid req_stall req_data              in         load or sample
//   rsp      rsp_valid rsp_stall rsp_data              out        one updated entry
//   csr      csr_wr_en csr_index csr_wr_data           in         register write
//
// A load transaction writes the memory at acceptance.
// A sample for element j issues 2j+1 entry updates, one a cycle through the
// memory read-modify-write path, and the next transaction is taken only once
// the last of them has left the update pipeline; a full result queue delays
// issue. Reset clears control state only; the matrix and the vector buffer
// hold nothing valid until written, and no clearing pass runs.
module ewma_covariance_update_unit
   import ecu_pkg::*;
#(
   parameter int MAX_DIM = MAX_DIM_DEFAULT
)(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  ecu_req_type                req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output ecu_rsp_type                rsp_data,
   input  logic                       csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0]   csr_wr_data
);

   localparam int DEPTH      = MAX_DIM * MAX_DIM;
   localparam int ADDR_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int IDX_BITS   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int STEP_BITS  = IDX_BITS + 1;
   localparam int FIFO_DEPTH = 4;
   localparam int FPTR_BITS  = $clog2(FIFO_DEPTH);
   localparam int FCNT_BITS  = FPTR_BITS + 1;

   logic [DECAY_BITS-1:0]          decay_ff, decay_in;
   logic [DIM_BITS-1:0]            dim_ff, dim_in;
   logic [IDX_BITS-1:0]            pos_ff, pos_in;
   logic                           act_ff, act_in;
   logic [IDX_BITS-1:0]            j_ff, j_in;
   logic [STEP_BITS-1:0]           step_ff, step_in;
   logic signed [SAMPLE_BITS-1:0]  s_ff, s_in;
   logic signed [SAMPLE_BITS-1:0]  vb_ff [MAX_DIM];

   logic signed [COV_BITS-1:0]     cov_mem [DEPTH];
   logic signed [COV_BITS-1:0]     rd_ff;

   ecu_rsp_type                    fifo_ff [FIFO_DEPTH];
   logic [FPTR_BITS-1:0]           wptr_ff, wptr_in;
   logic [FPTR_BITS-1:0]           rptr_ff, rptr_in;
   logic [FCNT_BITS-1:0]           cnt_ff, cnt_in;

   logic                           req_accept;
   logic                           sample_accept;
   logic                           load_we;
   logic [ADDR_BITS-1:0]           load_addr;
   logic [DIM_BITS-1:0]            dim_eff;
   logic [IDX_BITS-1:0]            cur_pos;
   logic [DIM_BITS-1:0]            next_pos;
   logic                           busy;
   logic [FCNT_BITS:0]             pending;
   logic                           issue;
   logic                           last_step;
   logic                           even_step;
   logic [IDX_BITS-1:0]            m_idx;
   logic [IDX_BITS-1:0]            row_idx;
   logic [IDX_BITS-1:0]            col_idx;
   logic [ADDR_BITS-1:0]           rd_addr;
   ecu_tag_type                    issue_tag;

   logic                           res_vld;
   ecu_rsp_type                    res;
   ecu_pipe_status_type            pipe_st;
   logic [ADDR_BITS-1:0]           res_addr;
   logic                           mem_we;
   logic [ADDR_BITS-1:0]           mem_waddr;
   logic signed [COV_BITS-1:0]     mem_wdata;
   logic                           pop;

   assign busy       = act_ff || pipe_st.s1_vld || pipe_st.s2_vld;
   assign req_stall  = reset || busy;
   assign req_accept = req_valid && !req_stall;
   assign sample_accept = req_accept && (req_data.cmd == CMD_SAMPLE);

   assign load_we   = req_accept && (req_data.cmd == CMD_LOAD)
                      && (int'(req_data.entry_row) < MAX_DIM)
                      && (int'(req_data.entry_col) < MAX_DIM);
   assign load_addr = ADDR_BITS'(int'(req_data.entry_row) * MAX_DIM
                                 + int'(req_data.entry_col));

   // effective dimension and start position of the incoming element
   always_comb begin
      if (dim_ff == '0) begin
         dim_eff = DIM_BITS'(1);
      end else if (int'(dim_ff) > MAX_DIM) begin
         dim_eff = DIM_BITS'(MAX_DIM);
      end else begin
         dim_eff = dim_ff;
      end
      cur_pos  = (DIM_BITS'(pos_ff) >= dim_eff) ? '0 : pos_ff;
      next_pos = DIM_BITS'(cur_pos) + DIM_BITS'(1);
   end

   // entry order: (j,m) then (m,j) for each m < j, (j,j) last
   always_comb begin
      pending   = FCNT_BITS'(cnt_ff) + (FCNT_BITS+1)'(pipe_st.s1_vld)
                  + (FCNT_BITS+1)'(pipe_st.s2_vld);
      issue     = act_ff && (int'(pending) < FIFO_DEPTH);
      last_step = (step_ff == {j_ff, 1'b0});
      even_step = !step_ff[0];
      m_idx     = step_ff[IDX_BITS:1];
      if (last_step || even_step) begin
         row_idx = j_ff;
         col_idx = last_step ? j_ff : m_idx;
      end else begin
         row_idx = m_idx;
         col_idx = j_ff;
      end
      rd_addr        = ADDR_BITS'(int'(row_idx) * MAX_DIM + int'(col_idx));
      issue_tag.row  = ENTRY_IDX_BITS'(row_idx);
      issue_tag.col  = ENTRY_IDX_BITS'(col_idx);
      issue_tag.last = last_step;
   end

   always_comb begin
      decay_in = decay_ff;
      dim_in   = dim_ff;
      pos_in   = pos_ff;
      act_in   = act_ff;
      j_in     = j_ff;
      step_in  = step_ff;
      s_in     = s_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_DECAY: begin
               decay_in = (csr_wr_data > DECAY_ONE) ? DECAY_ONE
                                                    : csr_wr_data[DECAY_BITS-1:0];
            end
            CSR_DIMENSION: begin
               dim_in = csr_wr_data[DIM_BITS-1:0];
               pos_in = '0;
            end
            default: begin
            end
         endcase
      end
      if (sample_accept) begin
         act_in  = 1'b1;
         j_in    = cur_pos;
         step_in = '0;
         s_in    = req_data.sample;
         pos_in  = (next_pos >= dim_eff) ? '0 : IDX_BITS'(next_pos);
      end else if (issue) begin
         step_in = step_ff + STEP_BITS'(1);
         if (last_step) begin
            act_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         decay_ff <= DECAY_RESET;
         dim_ff   <= DIM_RESET;
         pos_ff   <= '0;
         act_ff   <= 1'b0;
      end else begin
         decay_ff <= decay_in;
         dim_ff   <= dim_in;
         pos_ff   <= pos_in;
         act_ff   <= act_in;
      end
      j_ff    <= j_in;
      step_ff <= step_in;
      s_ff    <= s_in;
   end

   always_ff @(posedge clock) begin
      if (sample_accept) begin
         vb_ff[cur_pos] <= req_data.sample;
      end
   end

   ecu_update_pipe u_pipe (
      .clock     (clock),
      .reset     (reset),
      .issue_vld (issue),
      .issue_tag (issue_tag),
      .sample    (s_ff),
      .partner   (vb_ff[m_idx]),
      .old_value (rd_ff),
      .lambda    (decay_ff),
      .res_vld   (res_vld),
      .res       (res),
      .status    (pipe_st)
   );

   // loads are taken only while the pipeline is empty, so the ports never collide
   always_comb begin
      res_addr  = ADDR_BITS'(int'(res.out_row) * MAX_DIM + int'(res.out_col));
      mem_we    = load_we || res_vld;
      mem_waddr = res_vld ? res_addr : load_addr;
      mem_wdata = res_vld ? res.cov_value : req_data.init_value;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         cov_mem[mem_waddr] <= mem_wdata;
      end
      rd_ff <= cov_mem[rd_addr];
   end

   // result queue
   assign rsp_valid = !reset && (cnt_ff != '0);
   assign rsp_data  = fifo_ff[rptr_ff];
   assign pop       = rsp_valid && !rsp_stall;

   always_comb begin
      wptr_in = res_vld ? wptr_ff + FPTR_BITS'(1) : wptr_ff;
      rptr_in = pop ? rptr_ff + FPTR_BITS'(1) : rptr_ff;
      cnt_in  = cnt_ff + FCNT_BITS'(res_vld) - FCNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
      if (res_vld) begin
         fifo_ff[wptr_ff] <= res;
      end
   end

endmodule

### design/ecu_update_pipe.sv
// Two-stage multiply and round/saturate pipeline for one covariance entry.
// Depends on ecu_pkg; the old entry arrives from the memory in the cycle after issue.
module ecu_update_pipe
   import ecu_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          issue_vld,
   input  ecu_tag_type                   issue_tag,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   input  logic signed [SAMPLE_BITS-1:0] partner,
   input  logic signed [COV_BITS-1:0]    old_value,
   input  logic [DECAY_BITS-1:0]         lambda,
   output logic                          res_vld,
   output ecu_rsp_type                   res,
   output ecu_pipe_status_type           status
);

   localparam int HI_BITS   = COV_BITS - LAMBDA_FRAC;
   localparam int LAM_BITS  = DECAY_BITS + 1;
   localparam int PROD_BITS = 2 * SAMPLE_BITS;
   localparam int PHI_BITS  = HI_BITS + LAM_BITS;
   localparam int PLO_BITS  = LAMBDA_FRAC + DECAY_BITS;
   localparam int PW_BITS   = PROD_BITS + LAM_BITS;
   localparam int RND_BITS  = PLO_BITS + 1 - LAMBDA_FRAC;
   localparam int SUM_A     = (PHI_BITS > PW_BITS + 1) ? PHI_BITS : PW_BITS + 1;
   localparam int SUM_BITS  = SUM_A + 1;
   localparam logic [PLO_BITS:0] ROUND_HALF = (PLO_BITS+1)'(1) << (LAMBDA_FRAC - 1);

   logic                         s1_vld_ff, s1_vld_in;
   ecu_tag_type                  s1_tag_ff, s1_tag_in;
   logic signed [PROD_BITS-1:0]  prod_ff, prod_in;

   logic                         s2_vld_ff, s2_vld_in;
   ecu_tag_type                  s2_tag_ff, s2_tag_in;
   logic signed [PHI_BITS-1:0]   phi_ff, phi_in;
   logic [PLO_BITS-1:0]          plo_ff, plo_in;
   logic signed [PW_BITS-1:0]    pw_ff, pw_in;

   logic signed [HI_BITS-1:0]    old_hi;
   logic [LAMBDA_FRAC-1:0]       old_lo;
   logic signed [LAM_BITS-1:0]   lam_s;
   logic signed [LAM_BITS-1:0]   weight_s;
   logic [PLO_BITS:0]            rnd_full;
   logic [RND_BITS-1:0]          rnd;
   logic [SUM_BITS-1:0]          sum;
   logic                         in_range;

   // stage 1: u_j * u_m, old entry read from memory meanwhile
   always_comb begin
      s1_vld_in = issue_vld;
      s1_tag_in = issue_tag;
      prod_in   = sample * partner;
   end

   // stage 2: lambda * old (split at the Q15 point) and (1-lambda) * product
   always_comb begin
      old_hi    = old_value[COV_BITS-1:LAMBDA_FRAC];
      old_lo    = old_value[LAMBDA_FRAC-1:0];
      lam_s     = $signed({1'b0, lambda});
      weight_s  = $signed({1'b0, DECAY_ONE - lambda});
      s2_vld_in = s1_vld_ff;
      s2_tag_in = s1_tag_ff;
      phi_in    = old_hi * lam_s;
      plo_in    = old_lo * lambda;
      pw_in     = prod_ff * weight_s;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s1_vld_in;
         s2_vld_ff <= s2_vld_in;
      end
      s1_tag_ff <= s1_tag_in;
      prod_ff   <= prod_in;
      s2_tag_ff <= s2_tag_in;
      phi_ff    <= phi_in;
      plo_ff    <= plo_in;
      pw_ff     <= pw_in;
   end

   // round half up on the low part, add the doubled sample term, clip
   always_comb begin
      rnd_full = {1'b0, plo_ff} + ROUND_HALF;
      rnd      = rnd_full[PLO_BITS:LAMBDA_FRAC];
      sum      = SUM_BITS'($signed(phi_ff))
               + SUM_BITS'(rnd)
               + (SUM_BITS'($signed(pw_ff)) << 1);
      in_range = (&sum[SUM_BITS-1:COV_BITS-1]) || !(|sum[SUM_BITS-1:COV_BITS-1]);

      res.out_row   = s2_tag_ff.row;
      res.out_col   = s2_tag_ff.col;
      res.last      = s2_tag_ff.last;
      res.saturated = !in_range;
      if (in_range) begin
         res.cov_value = sum[COV_BITS-1:0];
      end else if (sum[SUM_BITS-1]) begin
         res.cov_value = COV_MIN_VAL;
      end else begin
         res.cov_value = COV_MAX_VAL;
      end
      res_vld       = s2_vld_ff;
      status.s1_vld = s1_vld_ff;
      status.s2_vld = s2_vld_ff;
   end

endmodule

### design/ecu_checker.sv
// Port-level checks of the EWMA covariance update unit, bound to its top level.
// Depends on ecu_pkg.
module ecu_checker
   import ecu_pkg::*;
#(
   parameter int MAX_DIM = MAX_DIM_DEFAULT
)(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input ecu_req_type  req_data,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input ecu_rsp_type  rsp_data
);

   // stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp transaction changed while stalled");

   // a sample keeps the input closed while its entries are issued
   a_sample_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_data.cmd == CMD_SAMPLE) |=> req_stall)
      else $error("input open right after a sample");

   // a load is done at acceptance
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_data.cmd == CMD_LOAD) |=> !req_stall)
      else $error("input stalled after a load");

   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (int'(rsp_data.out_row) < MAX_DIM) && (int'(rsp_data.out_col) < MAX_DIM))
      else $error("result entry outside the matrix");

   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.saturated
         |-> (rsp_data.cov_value == COV_MAX_VAL) || (rsp_data.cov_value == COV_MIN_VAL))
      else $error("saturated flag without a clipped value");

endmodule

bind ewma_covariance_update_unit ecu_checker #(.MAX_DIM(MAX_DIM)) u_ecu_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

### verif/testbench.sv
// Self-checking testbench for ewma_covariance_update_unit: drives load and sample
// transactions with random idling, predicts every updated covariance entry and
// compares the results in order. Depends on ecu_pkg and the unit's RTL.
module testbench
   import ecu_pkg::*;
();

   localparam int     MATRIX_DIM      = MAX_DIM_DEFAULT;
   localparam int     PHASES          = 7;
   localparam int     ITEMS_PER_PHASE = 57;
   localparam int     SETTLE_CYCLES   = 32;
   localparam int     TAIL_CYCLES     = 64;
   localparam int     RSP_HOLD_CYCLES = 400;
   // worst quiet stretch is the receiver hold plus one stalled 15-entry sample
   localparam int     QUIET_LIMIT     = 5000;
   localparam longint ENTRY_MAX       = 64'sd140737488355327;
   localparam longint ENTRY_MIN       = -64'sd140737488355328;

   localparam bit     STEP_REGISTER    = 1'b1;
   localparam bit     STEP_TRANSACTION = 1'b0;

   typedef struct {
      bit                        kind;
      logic [CSR_INDEX_BITS-1:0] reg_index;
      logic [CSR_DATA_BITS-1:0]  reg_value;
      ecu_req_type               request;
      bit                        known;
      logic [COV_BITS-1:0]       known_value;
   } script_step_type;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   ecu_req_type                req_data;
   logic                       rsp_valid;
   logic                       rsp_stall;
   ecu_rsp_type                rsp_data;
   logic                       csr_wr_en;
   logic [CSR_INDEX_BITS-1:0]  csr_index;
   logic [CSR_DATA_BITS-1:0]   csr_wr_data;

   // predicted state of the unit
   longint      cov_store  [MATRIX_DIM*MATRIX_DIM];
   bit          cov_loaded [MATRIX_DIM*MATRIX_DIM];
   longint      vec_store  [MATRIX_DIM];
   int          elem_pos;
   int          vec_len;
   int          decay_q15;
   ecu_rsp_type pending_entries [$];

   script_step_type script [$];

   int loads_sent      = 0;
   int samples_sent    = 0;
   int writes_done     = 0;
   int entries_checked = 0;
   int mismatches      = 0;
   int holds_asked     = 0;
   int holds_served    = 0;
   int quiet_cycles    = 0;
   bit rsp_relaxed     = 1'b0;

   ewma_covariance_update_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      mismatches++;
      $display("%0t mismatch: %s", $time, what);
   endtask

   // new = floor((lambda*old + half) / 2^15) + 2*(1-lambda)*prod, then clip to 48 bits
   function automatic longint blend_entry(input longint old, input longint prod,
                                          output bit clipped);
      longint lam;
      longint acc;
      lam = decay_q15;
      acc = ((lam * old + 64'sd16384) >>> 15) + 64'sd2 * (64'sd32768 - lam) * prod;
      clipped = 1'b0;
      if (acc > ENTRY_MAX) begin
         clipped = 1'b1;
         acc = ENTRY_MAX;
      end else if (acc < ENTRY_MIN) begin
         clipped = 1'b1;
         acc = ENTRY_MIN;
      end
      return acc;
   endfunction

   task automatic update_entry_at(input int r, input int c, input longint prod,
                                  input bit is_last);
      ecu_rsp_type e;
      bit          clipped;
      longint      nv;
      nv = blend_entry(cov_store[r*MATRIX_DIM + c], prod, clipped);
      cov_store[r*MATRIX_DIM + c] = nv;
      e.out_row   = r[ENTRY_IDX_BITS-1:0];
      e.out_col   = c[ENTRY_IDX_BITS-1:0];
      e.cov_value = nv[COV_BITS-1:0];
      e.saturated = clipped;
      e.last      = is_last;
      pending_entries.push_back(e);
   endtask

   task automatic predict_covariance(input ecu_req_type rq);
      int     idx;
      int     pos;
      longint s;
      longint u;
      if (rq.cmd == CMD_LOAD) begin
         idx = int'(rq.entry_row) * MATRIX_DIM + int'(rq.entry_col);
         cov_store[idx]  = {{(64-COV_BITS){rq.init_value[COV_BITS-1]}}, rq.init_value};
         cov_loaded[idx] = 1'b1;
         return;
      end
      pos = (elem_pos >= vec_len) ? 0 : elem_pos;
      s   = {{(64-SAMPLE_BITS){rq.sample[SAMPLE_BITS-1]}}, rq.sample};
      vec_store[pos] = s;
      for (int m = 0; m < pos; m++) begin
         u = vec_store[m];
         update_entry_at(pos, m, s * u, 1'b0);
         update_entry_at(m, pos, s * u, 1'b0);
      end
      update_entry_at(pos, pos, s * s, 1'b1);
      elem_pos = (pos + 1 >= vec_len) ? 0 : pos + 1;
   endtask

   task automatic apply_register(input logic [CSR_INDEX_BITS-1:0] idx,
                                 input logic [CSR_DATA_BITS-1:0] val);
      if (idx == CSR_DECAY) begin
         decay_q15 = (val > DECAY_ONE) ? int'(DECAY_ONE) : int'(val);
      end else begin
         vec_len = int'(val[DIM_BITS-1:0]);
         if (vec_len < 1) vec_len = 1;
         if (vec_len > MATRIX_DIM) vec_len = MATRIX_DIM;
         elem_pos = 0;
      end
   endtask

   function automatic ecu_req_type noise_request();
      logic [95:0] noise;
      noise = {$urandom, $urandom, $urandom};
      return noise[$bits(ecu_req_type)-1:0];
   endfunction

   function automatic ecu_req_type make_load(input logic [ENTRY_IDX_BITS-1:0] r,
                                             input logic [ENTRY_IDX_BITS-1:0] c,
                                             input logic [COV_BITS-1:0] v);
      ecu_req_type rq;
      rq = noise_request();
      rq.cmd        = CMD_LOAD;
      rq.entry_row  = r;
      rq.entry_col  = c;
      rq.init_value = v;
      return rq;
   endfunction

   function automatic ecu_req_type make_sample(input logic [SAMPLE_BITS-1:0] s);
      ecu_req_type rq;
      rq = noise_request();
      rq.cmd    = CMD_SAMPLE;
      rq.sample = s;
      return rq;
   endfunction

   function automatic logic [COV_BITS-1:0] random_entry_value();
      logic [63:0] bits64;
      bits64 = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0:       return COV_MAX_VAL;
         1:       return COV_MIN_VAL;
         2:       return '0;
         3, 4:    return {{(COV_BITS-32){bits64[31]}}, bits64[31:0]};
         default: return bits64[COV_BITS-1:0];
      endcase
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] random_sample();
      logic [31:0] bits32;
      bits32 = $urandom;
      case ($urandom_range(0, 7))
         0:       return 16'h7FFF;
         1:       return 16'h8000;
         2:       return '0;
         3:       return {{12{bits32[3]}}, bits32[3:0]};
         default: return bits32[SAMPLE_BITS-1:0];
      endcase
   endfunction

   function automatic int next_gap(input bit eager);
      int r;
      if (eager) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic script_step_type reg_row(input logic [CSR_INDEX_BITS-1:0] idx,
                                               input logic [CSR_DATA_BITS-1:0] val);
      script_step_type st;
      st.kind        = STEP_REGISTER;
      st.reg_index   = idx;
      st.reg_value   = val;
      st.request     = '0;
      st.known       = 1'b0;
      st.known_value = '0;
      return st;
   endfunction

   function automatic script_step_type load_row(input logic [ENTRY_IDX_BITS-1:0] r,
                                                input logic [ENTRY_IDX_BITS-1:0] c,
                                                input logic [COV_BITS-1:0] v);
      script_step_type st;
      st.kind        = STEP_TRANSACTION;
      st.reg_index   = CSR_DECAY;
      st.reg_value   = '0;
      st.request     = make_load(r, c, v);
      st.known       = 1'b0;
      st.known_value = '0;
      return st;
   endfunction

   function automatic script_step_type sample_row(input logic [SAMPLE_BITS-1:0] s,
                                                  input bit known,
                                                  input logic [COV_BITS-1:0] kv);
      script_step_type st;
      st.kind        = STEP_TRANSACTION;
      st.reg_index   = CSR_DECAY;
      st.reg_value   = '0;
      st.request     = make_sample(s);
      st.known       = known;
      st.known_value = kv;
      return st;
   endfunction

   // hold valid low through the requested gap, then offer the transaction until taken
   task automatic send_request(input ecu_req_type rq, input int gap);
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= rq;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_covariance(rq);
      if (rq.cmd == CMD_LOAD) loads_sent++;
      else samples_sent++;
   endtask

   task automatic idle_request_port();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_entries.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_BITS-1:0] idx,
                                 input logic [CSR_DATA_BITS-1:0] val);
      idle_request_port();
      wait_drained();
      // let the unit go idle before the register write
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= val;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      apply_register(idx, val);
      writes_done++;
   endtask

   // load every entry that the next sample reads and that holds nothing yet
   task automatic load_missing_entries(input bit eager);
      int pos;
      pos = (elem_pos >= vec_len) ? 0 : elem_pos;
      for (int m = 0; m <= pos; m++) begin
         if (!cov_loaded[pos*MATRIX_DIM + m])
            send_request(make_load(ENTRY_IDX_BITS'(pos), ENTRY_IDX_BITS'(m),
                                   random_entry_value()), next_gap(eager));
         if (!cov_loaded[m*MATRIX_DIM + pos])
            send_request(make_load(ENTRY_IDX_BITS'(m), ENTRY_IDX_BITS'(pos),
                                   random_entry_value()), next_gap(eager));
      end
   endtask

   // result side: random stalls, long holds on request, calm stretches
   initial begin
      int stall_left;
      int r;
      stall_left = 0;
      rsp_stall  = 1'b0;
      forever begin
         @(negedge clock);
         if (holds_served != holds_asked) begin
            holds_served++;
            rsp_stall <= 1'b1;
            repeat (RSP_HOLD_CYCLES) @(negedge clock);
            rsp_stall <= 1'b0;
         end else if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else if (rsp_relaxed) begin
            rsp_stall <= 1'b0;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 65) begin
               rsp_stall <= 1'b0;
            end else begin
               rsp_stall <= 1'b1;
               stall_left = (r < 92) ? $urandom_range(0, 2) : $urandom_range(9, 39);
            end
         end
      end
   end

   always @(posedge clock) begin : entry_check
      ecu_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_entries.size() == 0) begin
            report_mismatch($sformatf("unexpected entry (%0d,%0d) value %h",
                                      rsp_data.out_row, rsp_data.out_col,
                                      rsp_data.cov_value));
         end else begin
            want = pending_entries.pop_front();
            entries_checked++;
            if (rsp_data.out_row !== want.out_row || rsp_data.out_col !== want.out_col ||
                rsp_data.cov_value !== want.cov_value ||
                rsp_data.saturated !== want.saturated || rsp_data.last !== want.last)
               report_mismatch($sformatf(
                  "got (%0d,%0d) %h sat %b last %b, want (%0d,%0d) %h sat %b last %b",
                  rsp_data.out_row, rsp_data.out_col, rsp_data.cov_value,
                  rsp_data.saturated, rsp_data.last, want.out_row, want.out_col,
                  want.cov_value, want.saturated, want.last));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", quiet_cycles);
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int                       start_count;
      bit                       eager;
      bit                       paused;
      logic [CSR_DATA_BITS-1:0] decay_word;
      logic [CSR_DATA_BITS-1:0] dim_word;
      logic [DIM_BITS-1:0]      dim_val;
      ecu_rsp_type              spot;

      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_wr_en   = 1'b0;
      csr_index   = CSR_DECAY;
      csr_wr_data = '0;

      decay_q15 = int'(DECAY_RESET);
      vec_len   = int'(DIM_RESET);
      elem_pos  = 0;
      foreach (cov_loaded[k]) cov_loaded[k] = 1'b0;

      // values after reset, then the extremes of decay, dimension and data
      script.push_back(load_row(0, 0, 48'd65536));
      script.push_back(sample_row(16'd0, 1'b1, 48'd61604));
      script.push_back(reg_row(CSR_DIMENSION, 16'd1));
      script.push_back(reg_row(CSR_DECAY, DECAY_ONE));
      script.push_back(load_row(0, 0, COV_MAX_VAL));
      script.push_back(sample_row(16'h8000, 1'b1, COV_MAX_VAL));
      script.push_back(load_row(0, 0, COV_MIN_VAL));
      script.push_back(sample_row(16'h7FFF, 1'b1, COV_MIN_VAL));
      script.push_back(reg_row(CSR_DECAY, 16'd0));
      script.push_back(sample_row(16'h8000, 1'b1, 48'h4000_0000_0000));
      script.push_back(sample_row(16'h7FFF, 1'b1, 48'h3FFF_0001_0000));
      script.push_back(reg_row(CSR_DECAY, 16'hFFFF));
      script.push_back(load_row(0, 0, 48'h0000_1234_5678));
      script.push_back(sample_row(16'd1, 1'b1, 48'h0000_1234_5678));
      script.push_back(reg_row(CSR_DIMENSION, 16'd0));
      script.push_back(sample_row(16'hFFFF, 1'b0, '0));
      script.push_back(sample_row(16'd100, 1'b0, '0));
      script.push_back(reg_row(CSR_DECAY, 16'd16384));
      script.push_back(reg_row(CSR_DIMENSION, 16'd2));
      script.push_back(load_row(0, 0, 48'hFFFF_FFF0_0000));
      script.push_back(load_row(0, 1, 48'h0000_0123_4567));
      script.push_back(load_row(1, 0, 48'h8000_0000_0001));
      script.push_back(load_row(1, 1, 48'h7FFF_FFFF_FFFE));
      script.push_back(sample_row(16'h7FFF, 1'b0, '0));
      script.push_back(sample_row(16'h8000, 1'b0, '0));
      script.push_back(sample_row(16'h8000, 1'b0, '0));
      script.push_back(reg_row(CSR_DIMENSION, 16'd9));
      script.push_back(reg_row(CSR_DECAY, 16'h8001));
      script.push_back(sample_row(16'd5, 1'b0, '0));
      script.push_back(sample_row(16'hFFF9, 1'b0, '0));
      script.push_back(load_row(7, 7, 48'h5555_AAAA_5555));
      script.push_back(load_row(3, 5, 48'hAAAA_5555_AAAA));
      // dimension write in the middle of a vector restarts it
      script.push_back(reg_row(CSR_DIMENSION, 16'd1));
      script.push_back(sample_row(16'd0, 1'b0, '0));

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         if (script[i].kind == STEP_REGISTER) begin
            write_register(script[i].reg_index, script[i].reg_value);
         end else begin
            if (script[i].request.cmd == CMD_SAMPLE) load_missing_entries(1'b0);
            send_request(script[i].request, next_gap(1'b0));
            if (script[i].known) begin
               spot = pending_entries.pop_back();
               spot.cov_value = script[i].known_value;
               spot.saturated = 1'b0;
               spot.last      = 1'b1;
               pending_entries.push_back(spot);
            end
         end
      end

      paused = 1'b0;
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin decay_word = DECAY_RESET; dim_val = 4'd8;  end
            1: begin decay_word = 16'd0;       dim_val = 4'd1;  end
            2: begin decay_word = DECAY_ONE;   dim_val = 4'd3;  end
            3: begin decay_word = 16'hFFFF;    dim_val = 4'd0;  end
            4: begin
               decay_word = CSR_DATA_BITS'($urandom_range(0, 32768));
               dim_val    = 4'd15;
            end
            5: begin
               decay_word = CSR_DATA_BITS'($urandom_range(0, 65535));
               dim_val    = DIM_BITS'($urandom_range(1, 8));
            end
            default: begin decay_word = 16'h7FFF; dim_val = 4'd8;  end
         endcase
         dim_word = CSR_DATA_BITS'($urandom);
         dim_word[DIM_BITS-1:0] = dim_val;
         write_register(CSR_DECAY, decay_word);
         write_register(CSR_DIMENSION, dim_word);

         eager       = (phase == 2) || (phase == 4);
         rsp_relaxed = (phase == 4);
         // block the result side while the sender keeps pushing
         if (phase == 2) holds_asked++;

         start_count = loads_sent + samples_sent;
         while (loads_sent + samples_sent - start_count < ITEMS_PER_PHASE) begin
            if (phase == 5 && !paused &&
                loads_sent + samples_sent - start_count >= ITEMS_PER_PHASE / 2) begin
               paused = 1'b1;
               idle_request_port();
               wait_drained();
            end
            if ($urandom_range(0, 99) < 15) begin
               send_request(make_load(ENTRY_IDX_BITS'($urandom_range(0, 7)),
                                      ENTRY_IDX_BITS'($urandom_range(0, 7)),
                                      random_entry_value()), next_gap(eager));
            end else begin
               load_missing_entries(eager);
               send_request(make_sample(random_sample()), next_gap(eager));
            end
         end
      end

      rsp_relaxed = 1'b0;
      idle_request_port();
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Covered %0d transactions (%0d loads, %0d samples) across %0d register writes,",
               loads_sent + samples_sent, loads_sent, samples_sent, writes_done);
      $display("with %0d updated covariance entries compared in order.", entries_checked);
      if (mismatches == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule

### filelist.f
design/ecu_pkg.sv
design/ecu_update_pipe.sv
design/ewma_covariance_update_unit.sv
design/ecu_checker.sv
verif/testbench.sv
